@@ src/mimc_cube_root_round_core_assert.svh @@
// Assertion macros shared by the cube root round core.
`ifndef MIMC_CUBE_ROOT_ROUND_CORE_ASSERT_SVH
`define MIMC_CUBE_ROOT_ROUND_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MCR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define MCR_ASSERT_NEXT(lbl, clk, rstn, cond, res) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (res)) \
        else $error("%m failed");
`else
`define MCR_ASSERT(lbl, clk, rstn, prop)
`define MCR_ASSERT_NEXT(lbl, clk, rstn, cond, res)
`endif
`endif

@@ src/mcr_pkg.sv @@
// Types, constants and helpers for the cube root round core.
`timescale 1ns / 1ps
`default_nettype none
package mcr_pkg;
    localparam int unsigned W = 52;
    localparam logic [19:0] P_HIGH = 20'hfffff;
    localparam logic [31:0] P_LOW_RESET = 32'hffffffd1;
    localparam logic [2:0] ADDR_PRIME_LOW = 3'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_NEXT,
        S_EXP,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_RED,
        OP_SQ,
        OP_MULB,
        OP_CUBE1,
        OP_CUBE2
    } t_op;

    // One conditional subtraction; valid for x below twice the modulus.
    function automatic logic [W-1:0] red1(input logic [W-1:0] x, input logic [W-1:0] p);
        red1 = (x >= p) ? (x - p) : x;
    endfunction
endpackage
`default_nettype wire

@@ src/mimc_cube_root_round_core.sv @@
// Top level of the MiMC-style cube root / cube round core.
`timescale 1ns / 1ps
`default_nettype none
// One modular unit computes 2*acc + (bit ? b : 0) mod p each cycle, so a 52-bit
// modular multiply walks the 52 bits of its multiplier and the 64-bit input reduction
// the 64 bits of the input. A verify round is one reduction and two multiplies; a delay
// round walks the 53 exponent bits left to right with one square per bit and one extra
// multiply per set bit. The exponent bits come from a running division of 2p-1 by
// three, one bit per square. Ready is high only while no round is in progress; a
// finished result waits in the output register.
`include "mimc_cube_root_round_core_assert.svh"
module mimc_cube_root_round_core import mcr_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_psel,
    input  wire logic          i_penable,
    input  wire logic          i_pwrite,
    input  wire logic [2:0]    i_paddr,
    input  wire logic [31:0]   i_pwdata,
    output logic      [31:0]   o_prdata,
    output logic               o_pready,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_func,
    input  wire logic [63:0]   i_value,
    input  wire logic [63:0]   i_round_key,
    input  wire logic          i_last_round,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [W-1:0]       o_next_value,
    output logic [W-1:0]       o_reduced_value,
    output logic               o_chain_done
);
    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [31:0]  r_prime, n_prime;
    logic         r_ovalid, n_ovalid;
    logic         r_func, n_func, r_last, n_last, r_q, n_q;
    logic [W-1:0] r_key, n_key, r_p, n_p, r_v, n_v, r_base, n_base, r_pw, n_pw;
    logic [W-1:0] r_acc, n_acc, r_mb, n_mb, r_rnext, n_rnext, r_rred, n_rred;
    logic [63:0]  r_ma, n_ma;
    logic [W:0]   r_d, n_d;
    logic [1:0]   r_rem, n_rem;
    logic [6:0]   r_cnt, n_cnt;
    logic [5:0]   r_ecnt, n_ecnt;
    logic [W-1:0] r_onext, n_onext, r_ored, n_ored;
    logic         r_odone, n_odone;

    logic [W+1:0] sum, p1, p2, usum;
    logic [W-1:0] unit_out, x_diff, cube_sum;
    logic [2:0]   div_t;
    logic         div_q;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr == ADDR_PRIME_LOW) ? r_prime : 32'd0;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_next_value    = r_onext;
    assign o_reduced_value = r_ored;
    assign o_chain_done    = r_odone;

    // Shared modular step: the sum stays below three times the modulus.
    always_comb begin
        sum = {1'b0, r_acc, 1'b0} + (r_ma[63] ? {2'b00, r_mb} : {(W+2){1'b0}});
        p1 = {2'b00, r_p};
        p2 = {1'b0, r_p, 1'b0};
        if (sum >= p2) begin
            usum = sum - p2;
        end else if (sum >= p1) begin
            usum = sum - p1;
        end else begin
            usum = sum;
        end
        unit_out = usum[W-1:0];
        x_diff   = r_acc - r_key;
        cube_sum = r_acc + r_key;
        div_t    = {r_rem, r_d[W]};
        div_q    = (div_t >= 3'd3);
    end

    always_comb begin
        n_state = r_state; n_op = r_op; n_prime = r_prime; n_ovalid = r_ovalid;
        n_func = r_func; n_last = r_last; n_q = r_q; n_key = r_key; n_p = r_p;
        n_v = r_v; n_base = r_base; n_pw = r_pw; n_acc = r_acc; n_mb = r_mb;
        n_ma = r_ma; n_d = r_d; n_rem = r_rem; n_cnt = r_cnt; n_ecnt = r_ecnt;
        n_rnext = r_rnext; n_rred = r_rred;
        n_onext = r_onext; n_ored = r_ored; n_odone = r_odone;

        if (i_psel && i_penable && i_pwrite && (i_paddr == ADDR_PRIME_LOW)) begin
            n_prime = i_pwdata;
        end
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func = i_func;
                    n_key  = i_round_key[W-1:0];
                    n_last = i_last_round;
                    n_p    = {P_HIGH, r_prime};
                    n_ma   = i_value;
                    n_mb   = {{(W-1){1'b0}}, 1'b1};
                    n_acc  = '0;
                    n_cnt  = 7'd64;
                    n_op   = OP_RED;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_acc = unit_out;
                n_ma  = {r_ma[62:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_acc = '0;
                n_cnt = 7'd52;
                unique case (r_op)
                    OP_RED: begin
                        n_v = r_acc;
                        if (r_func) begin
                            n_ma = {r_acc, 12'd0};
                            n_mb = r_acc;
                            n_op = OP_CUBE1;
                            n_state = S_MUL;
                        end else begin
                            n_base = red1(x_diff, r_p);
                            n_d    = {r_p, 1'b0} - {{W{1'b0}}, 1'b1};
                            n_rem  = 2'd0;
                            n_ecnt = 6'd53;
                            n_pw   = {{(W-1){1'b0}}, 1'b1};
                            n_state = S_EXP;
                        end
                    end
                    OP_SQ: begin
                        n_pw = r_acc;
                        if (r_q) begin
                            n_ma = {r_acc, 12'd0};
                            n_mb = r_base;
                            n_op = OP_MULB;
                            n_state = S_MUL;
                        end else begin
                            n_state = S_EXP;
                        end
                    end
                    OP_MULB: begin
                        n_pw = r_acc;
                        n_state = S_EXP;
                    end
                    OP_CUBE1: begin
                        n_ma = {r_acc, 12'd0};
                        n_mb = r_v;
                        n_op = OP_CUBE2;
                        n_state = S_MUL;
                    end
                    OP_CUBE2: begin
                        n_rnext = cube_sum;
                        n_rred  = red1(cube_sum, r_p);
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_EXP: begin
                if (r_ecnt == 6'd0) begin
                    n_rnext = r_pw;
                    n_rred  = r_pw;
                    n_state = S_DONE;
                end else begin
                    n_q    = div_q;
                    n_rem  = div_q ? 2'(div_t - 3'd3) : div_t[1:0];
                    n_d    = {r_d[W-1:0], 1'b0};
                    n_ecnt = r_ecnt - 6'd1;
                    n_acc  = '0;
                    n_cnt  = 7'd52;
                    n_ma   = {r_pw, 12'd0};
                    n_mb   = r_pw;
                    n_op   = OP_SQ;
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_onext  = r_rnext;
                    n_ored   = r_rred;
                    n_odone  = r_last;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_RED;
            r_prime  <= P_LOW_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_prime  <= n_prime;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func; r_last <= n_last; r_q <= n_q; r_key <= n_key; r_p <= n_p;
        r_v <= n_v; r_base <= n_base; r_pw <= n_pw; r_acc <= n_acc; r_mb <= n_mb;
        r_ma <= n_ma; r_d <= n_d; r_rem <= n_rem; r_cnt <= n_cnt; r_ecnt <= n_ecnt;
        r_rnext <= n_rnext; r_rred <= n_rred;
        r_onext <= n_onext; r_ored <= n_ored; r_odone <= n_odone;
    end

    // The accumulator never leaves the range of residues while a multiply runs.
    `MCR_ASSERT(a_acc_reduced, i_clk, i_rst_n, (r_state == S_MUL) |-> (r_acc < r_p))
    `MCR_ASSERT_NEXT(a_start_red, i_clk, i_rst_n, i_valid && o_ready,
        (r_state == S_MUL) && (r_op == OP_RED) && (r_cnt == 7'd64))
    `MCR_ASSERT(a_cnt_live, i_clk, i_rst_n, (r_state == S_MUL) |-> (r_cnt != 7'd0))
endmodule
`default_nettype wire

@@ tb/sv/mimc_cube_root_round_core_test.sv @@
// Self-checking testbench for the cube root / cube round core.
`timescale 1ns / 1ps
module mimc_cube_root_round_core_test;
    import mcr_pkg::*;

    localparam logic [2:0]  ADDR_UNUSED = 3'd4;
    localparam logic [63:0] MASK52      = 64'h000f_ffff_ffff_ffff;
    localparam longint      CYCLE_LIMIT = 8000000;

    typedef struct packed {
        logic        func;
        logic [63:0] value;
        logic [63:0] round_key;
        logic        last_round;
    } round_item_t;

    typedef struct packed {
        logic [W-1:0] next_value;
        logic [W-1:0] reduced_value;
        logic         chain_done;
    } round_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_psel = 1'b0;
    logic i_penable = 1'b0;
    logic i_pwrite = 1'b0;
    logic [2:0] i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic o_pready;
    logic in_valid = 1'b0;
    logic o_ready;
    logic in_func = 1'b0;
    logic [63:0] in_value = '0;
    logic [63:0] in_key = '0;
    logic in_last = 1'b0;
    logic o_valid;
    logic out_ready = 1'b0;
    logic [W-1:0] o_next_value;
    logic [W-1:0] o_reduced_value;
    logic o_chain_done;

    round_item_t   pending_rounds[$];
    round_result_t expected_rounds[$];
    logic [31:0]   prime_low = P_LOW_RESET;
    logic          took = 1'b0;
    int            gap_left = 0;
    int            burst_left = 0;
    int            hold_left = 0;
    int            stall_mode = 0;
    int            mode_left = 0;
    bit            long_hold_req = 1'b0;
    int            mismatches = 0;
    longint        cycles = 0;

    mimc_cube_root_round_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite),
        .i_paddr(i_paddr), .i_pwdata(i_pwdata), .o_prdata(o_prdata), .o_pready(o_pready),
        .i_valid(in_valid), .o_ready(o_ready),
        .i_func(in_func), .i_value(in_value), .i_round_key(in_key),
        .i_last_round(in_last),
        .o_valid(o_valid), .i_ready(out_ready),
        .o_next_value(o_next_value), .o_reduced_value(o_reduced_value),
        .o_chain_done(o_chain_done)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] m);
        logic [127:0] prod;
        prod = 128'(a % m) * 128'(b % m);
        return 64'(prod % 128'(m));
    endfunction

    function automatic round_result_t predict_round(input round_item_t it,
                                                    input logic [31:0] low);
        logic [63:0] p;
        logic [63:0] key;
        logic [63:0] expo;
        logic [63:0] base;
        logic [63:0] acc;
        logic [63:0] nxt;
        round_result_t r;
        p = {12'd0, P_HIGH, low};
        key = it.round_key & MASK52;
        if (it.func == 1'b0) begin
            expo = (p * 64'd2 - 64'd1) / 64'd3;
            base = (((it.value % p) - key) & MASK52) % p;
            acc = 64'd1;
            while (expo != 0) begin
                if (expo[0])
                    acc = mul_mod(acc, base, p);
                expo = expo >> 1;
                if (expo != 0)
                    base = mul_mod(base, base, p);
            end
            nxt = acc;
        end else begin
            nxt = (mul_mod(mul_mod(it.value, it.value, p), it.value, p) + key) & MASK52;
        end
        r.next_value = nxt[W-1:0];
        r.reduced_value = 52'(nxt % p);
        r.chain_done = it.last_round;
        return r;
    endfunction

    // Acceptance and prediction at the rising edge.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (in_valid && o_ready) begin
            expected_rounds.push_back(predict_round({in_func, in_value, in_key, in_last},
                                                    prime_low));
            took <= 1'b1;
        end else begin
            took <= 1'b0;
        end
    end

    // Driver: bursts of items separated by random gaps.
    always @(negedge i_clk) begin
        logic nv;
        round_item_t it;
        if (i_rst_n && (!in_valid || took)) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_rounds.size() > 0) begin
                it = pending_rounds.pop_front();
                in_func <= it.func;
                in_value <= it.value;
                in_key <= it.round_key;
                in_last <= it.last_round;
                nv = 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(12, 0);
                    gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(400, 0);
                end else begin
                    burst_left--;
                end
            end
            in_valid <= nv;
        end
    end

    // Receiver: a changing stall pattern, plus one long hold-off on request.
    always @(negedge i_clk) begin
        logic rdy;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 3000;
            rdy = 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(2, 0);
                mode_left = $urandom_range(2000, 50);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(1, 0);
                default: rdy = ($urandom_range(3, 0) == 0);
            endcase
        end
        out_ready <= i_rst_n && rdy;
    end

    // Monitor: compare each transaction with the oldest prediction.
    always @(posedge i_clk) begin
        round_result_t want;
        if (i_rst_n && o_valid && out_ready) begin
            if (expected_rounds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: next %h reduced %h done %b",
                             o_next_value, o_reduced_value, o_chain_done);
            end else begin
                want = expected_rounds.pop_front();
                if (want.next_value !== o_next_value || want.reduced_value !== o_reduced_value
                        || want.chain_done !== o_chain_done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %h %h %b, got %h %h %b",
                                 want.next_value, want.reduced_value, want.chain_done,
                                 o_next_value, o_reduced_value, o_chain_done);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        i_psel <= 1'b1;
        i_pwrite <= 1'b1;
        i_penable <= 1'b0;
        i_paddr <= addr;
        i_pwdata <= data;
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(negedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        if (addr == ADDR_PRIME_LOW)
            prime_low = data;
    endtask

    task automatic drain_rounds();
        while (pending_rounds.size() > 0 || in_valid || expected_rounds.size() > 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic add_round(input logic f, input logic [63:0] v, input logic [63:0] k,
                             input logic last);
        round_item_t it;
        it.func = f;
        it.value = v;
        it.round_key = k;
        it.last_round = last;
        pending_rounds.push_back(it);
    endtask

    // Mostly verify rounds, since a delay round runs a full modular exponentiation.
    task automatic add_random_rounds(input int count);
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] k;
        p = {12'd0, P_HIGH, prime_low};
        for (int n = 0; n < count; n++) begin
            k = {$urandom, $urandom};
            case ($urandom_range(5, 0))
                0: v = p + $urandom_range(3, 0) - 2;
                1: v = $urandom_range(7, 0);
                2: v = {$urandom, $urandom} & MASK52;
                default: v = {$urandom, $urandom};
            endcase
            if ($urandom_range(3, 0) == 0)
                k = (v % p) ^ {$urandom, 32'd0};
            add_round($urandom_range(24, 0) == 0 ? 1'b0 : 1'b1, v, k, $urandom_range(1, 0));
        end
    endtask

    initial begin
        logic [63:0] p;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        p = {12'd0, P_HIGH, prime_low};
        // Extremes of the fields, values at and around the modulus, and a zero base.
        add_round(1'b0, 64'd0, 64'd0, 1'b0);
        add_round(1'b1, 64'd0, 64'd0, 1'b1);
        add_round(1'b0, '1, '1, 1'b1);
        add_round(1'b1, '1, '1, 1'b0);
        add_round(1'b0, p, 64'd0, 1'b0);
        add_round(1'b1, p, 64'd5, 1'b0);
        add_round(1'b1, p - 1, MASK52, 1'b1);
        add_round(1'b1, p + 1, 64'hfff0_0000_0000_0000, 1'b0);
        add_round(1'b0, 64'd12345, 64'hfff0_0000_0000_3039, 1'b1);
        add_round(1'b0, 64'd1, 64'd0, 1'b0);
        add_round(1'b1, MASK52, 64'd1, 1'b0);
        add_round(1'b0, p - 1, 64'd2, 1'b1);
        add_round(1'b1, 64'd2, 64'd3, 1'b1);
        add_round(1'b1, {32'd0, 32'hffff_ffff}, 64'h8000_0000_0000_0000, 1'b0);
        drain_rounds();
        long_hold_req = 1'b1;
        add_random_rounds(400);
        drain_rounds();
        apb_write(ADDR_PRIME_LOW, 32'h0000_0000);
        add_random_rounds(350);
        drain_rounds();
        apb_write(ADDR_PRIME_LOW, 32'hffff_ffff);
        // A write beyond the register map must leave the modulus alone.
        apb_write(ADDR_UNUSED, 32'h1234_5678);
        add_random_rounds(350);
        drain_rounds();
        apb_write(ADDR_PRIME_LOW, $urandom);
        add_random_rounds(350);
        drain_rounds();
        apb_write(ADDR_PRIME_LOW, P_LOW_RESET);
        add_random_rounds(350);
        drain_rounds();
        repeat (200) @(negedge i_clk);
        if (mismatches == 0 && expected_rounds.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
